/* rtl/frr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frr_pkg: shared types and constants of the flat region ratio block
// Field widths, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
package frr_pkg;

	localparam int CFG_W     = 13;
	localparam int CHAN_W    = 8;
	localparam int QUANT_W   = 5;
	localparam int COLOR_W   = 3 * QUANT_W;
	localparam int COUNT_W   = 25;
	localparam int RATIO_W   = 17;
	localparam int DIV_STEPS = RATIO_W;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);
	localparam int REG_IDX_W = 2;
	localparam int QUEUE_CNT_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_PIXEL_MODE   = 2'd2;

	localparam logic [QUEUE_CNT_W-1:0] QUEUE_EMPTY = 2'd0;
	localparam logic [QUEUE_CNT_W-1:0] QUEUE_ONE   = 2'd1;
	localparam logic [QUEUE_CNT_W-1:0] QUEUE_FULL  = 2'd2;

	typedef struct packed {
		logic [CFG_W-1:0] width;
		logic [CFG_W-1:0] height;
		logic             color;
	} cfg_t;

endpackage

/* rtl/frr_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frr_queue: two-entry queue of frame totals
// Decouples the pixel front end from the ratio divider.
// ----------------------------------------------------------------------------
module frr_queue
	import frr_pkg::*;
#(
	parameter int DATA_W = 52
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [DATA_W-1:0]      push_data,
	input  logic                   pop,
	output logic [DATA_W-1:0]      pop_data,
	output logic [QUEUE_CNT_W-1:0] count
);

	logic [DATA_W-1:0]      entry_q [2];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= QUEUE_EMPTY;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + QUEUE_ONE;
			else if (pop && !push) count_q <= count_q - QUEUE_ONE;
		end
	end

	assign pop_data = entry_q[rd_ptr_q];
	assign count    = count_q;

endmodule

/* rtl/frr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frr_front: pixel front end
// Quantizes pixels, compares with left and upper neighbors through a line
// store, and accumulates match and comparison totals per frame.
// ----------------------------------------------------------------------------
module frr_front
	import frr_pkg::*;
#(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096,
	parameter int CNT_W      = 26
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   restart,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [CHAN_W-1:0]      chan_red,
	input  logic [CHAN_W-1:0]      chan_green,
	input  logic [CHAN_W-1:0]      chan_blue,
	input  logic [QUEUE_CNT_W-1:0] q_count,
	output logic                   push,
	output logic [CNT_W-1:0]       push_match,
	output logic [CNT_W-1:0]       push_compare
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int WX_W  = CFG_W + $clog2(MAX_WIDTH + 1);
	localparam int HX_W  = CFG_W + $clog2(MAX_HEIGHT + 1);
	localparam logic [WX_W-1:0] W_MAX = WX_W'(MAX_WIDTH);
	localparam logic [HX_W-1:0] H_MAX = HX_W'(MAX_HEIGHT);

	logic [WX_W-1:0]    w_ext;
	logic [HX_W-1:0]    h_ext;
	logic [WX_W-1:0]    w_dec;
	logic [HX_W-1:0]    h_dec;
	logic [COL_W-1:0]   w_last;
	logic [ROW_W-1:0]   h_last;
	logic               active;
	logic               accept;
	logic [QUANT_W-1:0] r5;
	logic [QUANT_W-1:0] g5;
	logic [QUANT_W-1:0] b5;
	logic [COLOR_W-1:0] q;
	logic               row_end;
	logic               frame_end;

	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [COLOR_W-1:0] left_q;
	logic [CNT_W-1:0]   match_q;
	logic [CNT_W-1:0]   compare_q;

	logic [COLOR_W-1:0] line_mem [MAX_WIDTH];

	logic               valid_s1;
	logic               last_s1;
	logic [COLOR_W-1:0] q_s1;
	logic [COLOR_W-1:0] up_s1;
	logic               left_cmp_s1;
	logic               left_hit_s1;
	logic               up_cmp_s1;

	logic               up_hit;
	logic [1:0]         inc_c;
	logic [1:0]         inc_m;
	logic [CNT_W-1:0]   match_sum;
	logic [CNT_W-1:0]   compare_sum;

	assign w_ext = {{(WX_W-CFG_W){1'b0}}, cfg.width};
	assign h_ext = {{(HX_W-CFG_W){1'b0}}, cfg.height};
	assign w_dec = w_ext - WX_W'(1);
	assign h_dec = h_ext - HX_W'(1);

	always_comb begin
		priority if (cfg.width == '0) w_last = '0;
		else if (w_ext > W_MAX) w_last = COL_W'(MAX_WIDTH - 1);
		else w_last = w_dec[COL_W-1:0];
		priority if (cfg.height == '0) h_last = '0;
		else if (h_ext > H_MAX) h_last = ROW_W'(MAX_HEIGHT - 1);
		else h_last = h_dec[ROW_W-1:0];
	end

	assign active = (w_last != '0) && (h_last != '0);

	assign in_stall = (q_count == QUEUE_FULL) ||
		((q_count == QUEUE_ONE) && valid_s1 && last_s1);
	assign accept = in_valid && !in_stall;

	assign r5 = chan_red[CHAN_W-1 -: QUANT_W];
	assign g5 = cfg.color ? chan_green[CHAN_W-1 -: QUANT_W] : r5;
	assign b5 = cfg.color ? chan_blue[CHAN_W-1 -: QUANT_W] : r5;
	assign q  = {r5, g5, b5};

	assign row_end   = (col_q == w_last);
	assign frame_end = row_end && (row_q == h_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (restart) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (accept) begin
			left_q <= q;
			if (row_end) begin
				col_q <= '0;
				if (frame_end) row_q <= '0;
				else row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			up_s1           <= line_mem[col_q];
			line_mem[col_q] <= q;
			q_s1            <= q;
			left_cmp_s1     <= active && (col_q != '0);
			left_hit_s1     <= active && (col_q != '0) && (left_q == q);
			up_cmp_s1       <= active && (row_q != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) last_s1 <= frame_end;
		end
	end

	assign up_hit      = up_cmp_s1 && (up_s1 == q_s1);
	assign inc_c       = {1'b0, left_cmp_s1} + {1'b0, up_cmp_s1};
	assign inc_m       = {1'b0, left_hit_s1} + {1'b0, up_hit};
	assign match_sum   = match_q + CNT_W'(inc_m);
	assign compare_sum = compare_q + CNT_W'(inc_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q   <= '0;
			compare_q <= '0;
		end else if (restart) begin
			match_q   <= '0;
			compare_q <= '0;
		end else if (valid_s1) begin
			if (last_s1) begin
				match_q   <= '0;
				compare_q <= '0;
			end else begin
				match_q   <= match_sum;
				compare_q <= compare_sum;
			end
		end
	end

	assign push         = valid_s1 && last_s1;
	assign push_match   = match_sum;
	assign push_compare = compare_sum;

endmodule

/* rtl/frr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frr_back: frame result back end
// Divides matches by comparisons one quotient bit per cycle and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module frr_back
	import frr_pkg::*;
#(
	parameter int CNT_W = 26
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [QUEUE_CNT_W-1:0] q_count,
	input  logic [CNT_W-1:0]       q_match,
	input  logic [CNT_W-1:0]       q_compare,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [COUNT_W-1:0]     match_count,
	output logic [COUNT_W-1:0]     comparison_count,
	output logic [RATIO_W-1:0]     flat_ratio_q16
);

	localparam int REM_W = CNT_W + 1;
	localparam int EXT_W = CNT_W + COUNT_W;

	logic               busy_q;
	logic [STEP_W-1:0]  step_q;
	logic [REM_W-1:0]   rem_q;
	logic [RATIO_W-1:0] quo_q;
	logic [CNT_W-1:0]   m_q;
	logic [CNT_W-1:0]   c_q;

	logic               out_valid_q;
	logic [COUNT_W-1:0] match_q;
	logic [COUNT_W-1:0] compare_q;
	logic [RATIO_W-1:0] ratio_q;

	logic               done;
	logic               slot_free;
	logic [REM_W-1:0]   div_ext;
	logic               ge;
	logic [REM_W-1:0]   rem_sub;
	logic [EXT_W-1:0]   m_ext;
	logic [EXT_W-1:0]   c_ext;

	assign pop       = (q_count != QUEUE_EMPTY) && !busy_q;
	assign done      = busy_q && (step_q == STEP_W'(DIV_STEPS));
	assign slot_free = !out_valid_q || !out_stall;
	assign div_ext   = {1'b0, c_q};
	assign ge        = rem_q >= div_ext;
	assign rem_sub   = ge ? (rem_q - div_ext) : rem_q;
	assign m_ext     = {{COUNT_W{1'b0}}, m_q};
	assign c_ext     = {{COUNT_W{1'b0}}, c_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (done && slot_free) begin
				busy_q <= 1'b0;
			end else if (busy_q && !done) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (done && slot_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rem_q <= {1'b0, q_match};
			quo_q <= '0;
			m_q   <= q_match;
			c_q   <= q_compare;
		end else if (busy_q && !done) begin
			rem_q <= {rem_sub[REM_W-2:0], 1'b0};
			quo_q <= {quo_q[RATIO_W-2:0], ge};
		end
		if (done && slot_free) begin
			match_q   <= m_ext[COUNT_W-1:0];
			compare_q <= c_ext[COUNT_W-1:0];
			ratio_q   <= (c_q == '0) ? '0 : quo_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign match_count      = match_q;
	assign comparison_count = compare_q;
	assign flat_ratio_q16   = ratio_q;

endmodule

/* rtl/flat_region_ratio.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flat_region_ratio: flat region statistics of a raster-order frame
// Pixels enter in raster order on the input channel (in_valid/in_stall), one
// request per cycle while not stalled. Each pixel is cut to 5 bits per
// channel and compared with its left and upper neighbors; a one-row line
// store holds the row above. On the last pixel of a frame one request leaves
// on the output channel (out_valid/out_stall) with the match count,
// comparison count and the floored match fraction in Q1.16.
// Throughput: one pixel per cycle while not stalled. The frame-end fraction
// comes from a restoring divider that makes one quotient bit per cycle; its
// result goes to the output register once the divider is done. Two frame
// totals can wait between front end and divider; input stalls while that
// queue is full or about to fill, as with frames of one pixel each.
// Output stall holds the result register; the divider waits behind it.
// Reset clears positions, counters and queues and sets width and height to
// one, gray mode. The line store is not cleared. A write to the width, height
// or pixel mode register restarts the frame.
// ----------------------------------------------------------------------------
module flat_region_ratio
	import frr_pkg::*;
#(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CHAN_W-1:0]    chan_red,
	input  logic [CHAN_W-1:0]    chan_green,
	input  logic [CHAN_W-1:0]    chan_blue,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [COUNT_W-1:0]   match_count,
	output logic [COUNT_W-1:0]   comparison_count,
	output logic [RATIO_W-1:0]   flat_ratio_q16
);

	localparam int CNT_W = $clog2(2 * MAX_WIDTH * MAX_HEIGHT);

	cfg_t                   cfg_q;
	logic                   restart;
	logic                   q_push;
	logic                   q_pop;
	logic [CNT_W-1:0]       push_match;
	logic [CNT_W-1:0]       push_compare;
	logic [2*CNT_W-1:0]     pop_data;
	logic [QUEUE_CNT_W-1:0] q_count;

	always_comb begin
		restart = 1'b0;
		if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  restart = 1'b1;
				REG_IMAGE_HEIGHT: restart = 1'b1;
				REG_PIXEL_MODE:   restart = 1'b1;
				default:          restart = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= CFG_W'(1);
			cfg_q.height <= CFG_W'(1);
			cfg_q.color  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  cfg_q.width  <= cfg_data;
				REG_IMAGE_HEIGHT: cfg_q.height <= cfg_data;
				REG_PIXEL_MODE:   cfg_q.color  <= cfg_data[0];
				default:          cfg_q        <= cfg_q;
			endcase
		end
	end

	frr_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.CNT_W      (CNT_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.restart      (restart),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.chan_red     (chan_red),
		.chan_green   (chan_green),
		.chan_blue    (chan_blue),
		.q_count      (q_count),
		.push         (q_push),
		.push_match   (push_match),
		.push_compare (push_compare)
	);

	frr_queue #(
		.DATA_W (2 * CNT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_match, push_compare}),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.count     (q_count)
	);

	frr_back #(
		.CNT_W (CNT_W)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_count          (q_count),
		.q_match          (pop_data[2*CNT_W-1:CNT_W]),
		.q_compare        (pop_data[CNT_W-1:0]),
		.pop              (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.match_count      (match_count),
		.comparison_count (comparison_count),
		.flat_ratio_q16   (flat_ratio_q16)
	);

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_count != QUEUE_FULL) || q_pop)
		else $error("frame totals pushed into a full queue");

	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> flat_ratio_q16 <= RATIO_W'(65536))
		else $error("ratio above one");

	a_full_queue_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(q_count == QUEUE_FULL) |-> in_stall)
		else $error("input taken while queue full");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_count != QUEUE_EMPTY)
		else $error("pop from empty queue");

endmodule
